// ----- rtl/core/paes_pkg.sv -----
// Shared types and constants for the pitch and amplitude envelope step block.
package paes_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] PH_ATTACK  = 2'd0;
	localparam logic [1:0] PH_DECAY   = 2'd1;
	localparam logic [1:0] PH_SUSTAIN = 2'd2;
	localparam logic [1:0] PH_RELEASE = 2'd3;

	localparam logic [2:0] CFG_STEP_LENGTH      = 3'd0;
	localparam logic [2:0] CFG_NO_REPEAT        = 3'd1;
	localparam logic [2:0] CFG_PITCH_INCREMENTS = 3'd2;
	localparam logic [2:0] CFG_PITCH_COUNTS     = 3'd3;
	localparam logic [2:0] CFG_AMPLITUDE_RATES  = 3'd4;
	localparam logic [2:0] CFG_AMPLITUDE_LEVELS = 3'd5;

	localparam logic [9:0] STEP_MAX = 10'd1023;

	typedef struct packed {
		logic [7:0] amp;
		logic [7:0] offset;
		logic [7:0] note;
		logic [1:0] phase;
		logic [6:0] tick;
		logic [9:0] steps;
		logic [9:0] pos;
	} chan_t;

endpackage

// ----- rtl/core/pitch_amplitude_envelope_step.sv -----
// Envelope step engine: per-channel state in a memory, read-modify-write pipeline.
//
// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
// in        in_valid / in_stall      action, channel_index, base_pitch, next_waiting
// out       out_valid / out_stall    pitch, amplitude, phase, finished
//
// One item is accepted per cycle while in_stall is low; it is registered in the compute stage
// and then in the output register, where it holds while out_stall is high.
// The channel state memory is read at acceptance and written back when the item leaves
// the compute stage; a bypass register covers back-to-back items on the same channel.
// Reset clears the configuration and the per-channel valid bits at once.
// A stalled output holds the item in the compute stage and stalls the input.
module pitch_amplitude_envelope_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [1:0]  channel_index,
	input  logic [7:0]  base_pitch,
	input  logic        next_waiting,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pitch,
	output logic [7:0]  amplitude,
	output logic [1:0]  phase,
	output logic        finished
);

	logic [6:0]  step_len_q;
	logic        no_rep_q;
	logic [23:0] pinc_q;
	logic [23:0] pcnt_q;
	logic [31:0] rates_q;
	logic [15:0] levels_q;

	paes_pkg::chan_t mem [paes_pkg::NUM_CHANNELS];
	logic [paes_pkg::NUM_CHANNELS-1:0] vld_q;

	logic                      vld_s1;
	logic [1:0]                act_s1;
	logic [paes_pkg::CH_W-1:0] ch_s1;
	logic [7:0]                base_s1;
	logic                      wait_s1;
	logic                      range_s1;
	logic                      rvld_s1;
	logic                      fwd_s1;
	paes_pkg::chan_t           rd_s1;
	paes_pkg::chan_t           byp_q;

	logic                      out_vld_q;
	logic [7:0]                pitch_q;
	logic [7:0]                amp_q;
	logic [1:0]                phase_q;
	logic                      fin_q;

	logic                      adv;
	logic                      in_fire;
	logic                      wr_en;
	logic                      in_range;
	logic [paes_pkg::CH_W-1:0] ch_addr;
	paes_pkg::chan_t           cur;
	paes_pkg::chan_t           nxt;
	logic                      done;

	assign cfg_ready = 1'b1;
	assign adv       = !out_vld_q || !out_stall;
	assign in_stall  = vld_s1 && !adv;
	assign in_fire   = in_valid && !in_stall;
	assign wr_en     = vld_s1 && adv && range_s1;
	assign in_range  = int'(channel_index) < paes_pkg::NUM_CHANNELS;
	assign ch_addr   = paes_pkg::CH_W'(channel_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q <= '0;
			no_rep_q   <= 1'b0;
			pinc_q     <= '0;
			pcnt_q     <= '0;
			rates_q    <= '0;
			levels_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				paes_pkg::CFG_STEP_LENGTH:      step_len_q <= cfg_data[6:0];
				paes_pkg::CFG_NO_REPEAT:        no_rep_q   <= cfg_data[0];
				paes_pkg::CFG_PITCH_INCREMENTS: pinc_q     <= cfg_data[23:0];
				paes_pkg::CFG_PITCH_COUNTS:     pcnt_q     <= cfg_data[23:0];
				paes_pkg::CFG_AMPLITUDE_RATES:  rates_q    <= cfg_data;
				paes_pkg::CFG_AMPLITUDE_LEVELS: levels_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ch_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_range) begin
			rd_s1 <= mem[ch_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1   <= action;
			ch_s1    <= ch_addr;
			base_s1  <= base_pitch;
			wait_s1  <= next_waiting;
			range_s1 <= in_range;
		end
		if (wr_en) begin
			byp_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_s1  <= 1'b0;
			rvld_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[ch_s1] <= 1'b1;
			end
			if (in_fire) begin
				vld_s1  <= 1'b1;
				rvld_s1 <= in_range && vld_q[ch_addr];
				fwd_s1  <= wr_en && (ch_s1 == ch_addr);
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		logic [9:0] n1;
		logic [9:0] n2;
		logic [9:0] n3;
		logic [9:0] total;
		logic [9:0] p;
		logic [7:0] inc;
		logic [7:0] t;
		logic [7:0] amp_v;
		cur   = fwd_s1 ? byp_q : (rvld_s1 ? rd_s1 : '0);
		nxt   = cur;
		done  = 1'b0;
		n1    = {2'b00, pcnt_q[7:0]};
		n2    = {2'b00, pcnt_q[15:8]};
		n3    = {2'b00, pcnt_q[23:16]};
		total = n1 + n2 + n3;
		p     = cur.pos;
		inc   = '0;
		t     = {1'b0, cur.tick} + 8'd1;
		amp_v = cur.amp;
		case (act_s1)
			paes_pkg::ACT_START: begin
				nxt      = '0;
				nxt.note = base_s1;
			end
			paes_pkg::ACT_TICK: begin
				if (step_len_q != 7'd0) begin
					if (t >= {1'b0, step_len_q}) begin
						nxt.tick = '0;
						if (cur.steps != paes_pkg::STEP_MAX) begin
							nxt.steps = cur.steps + 10'd1;
						end
						if (total != 10'd0) begin
							if (no_rep_q && (p >= total)) begin
								nxt.offset = '0;
							end else begin
								if (p >= total) begin
									p = '0;
								end
								if (p < n1) begin
									inc = pinc_q[7:0];
								end else if (p < n1 + n2) begin
									inc = pinc_q[15:8];
								end else begin
									inc = pinc_q[23:16];
								end
								nxt.offset = cur.offset + inc;
								p = p + 10'd1;
								if (!no_rep_q && (p >= total)) begin
									p = '0;
								end
								nxt.pos = p;
							end
						end
						case (cur.phase)
							paes_pkg::PH_ATTACK: begin
								amp_v = cur.amp + rates_q[7:0];
								if (amp_v >= levels_q[7:0]) begin
									nxt.phase = paes_pkg::PH_DECAY;
								end
							end
							paes_pkg::PH_DECAY: begin
								amp_v = cur.amp + rates_q[15:8];
								if (amp_v <= levels_q[15:8]) begin
									nxt.phase = paes_pkg::PH_SUSTAIN;
								end
							end
							paes_pkg::PH_SUSTAIN: begin
								amp_v = cur.amp + rates_q[23:16];
								if (amp_v == 8'd0) begin
									nxt.phase = paes_pkg::PH_RELEASE;
								end
							end
							default: begin
								amp_v = cur.amp + rates_q[31:24];
								done  = (amp_v == 8'd0) || wait_s1;
							end
						endcase
						nxt.amp = amp_v;
					end else begin
						nxt.tick = t[6:0];
					end
				end
			end
			paes_pkg::ACT_RELEASE: begin
				nxt.phase = paes_pkg::PH_RELEASE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			if (range_s1) begin
				pitch_q <= nxt.note + nxt.offset;
				amp_q   <= nxt.amp;
				phase_q <= nxt.phase;
				fin_q   <= done;
			end else begin
				pitch_q <= '0;
				amp_q   <= '0;
				phase_q <= '0;
				fin_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign pitch     = pitch_q;
	assign amplitude = amp_q;
	assign phase     = phase_q;
	assign finished  = fin_q;

`ifndef ASSERT_OFF
	a_fin_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> phase == paes_pkg::PH_RELEASE)
		else $error("finished result outside the release phase");

	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && wr_en && (ch_s1 == ch_addr) |=> fwd_s1)
		else $error("same-channel item missed the bypass");

	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && fwd_s1 |-> vld_q[ch_s1])
		else $error("bypass used for a channel never written");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(ch_s1) && $stable(act_s1))
		else $error("compute stage lost a stalled item");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv && range_s1 && (act_s1 == paes_pkg::ACT_START)
		|=> out_valid && amplitude == 8'd0 && phase == paes_pkg::PH_ATTACK)
		else $error("start item did not clear the channel");
`endif

endmodule
